/* rtl/aoc_pkg.sv */
// ----------------------------------------------------------------------------
// aoc_pkg: shared types and constants for the airspeed offset/convert unit
// Sample count, widths, register indexes and controller states.
// ----------------------------------------------------------------------------
package aoc_pkg;

    localparam int SAMPLES      = 64;
    localparam int IDX_W        = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CNT_W        = $clog2(SAMPLES + 1);
    localparam int DROP         = (SAMPLES > 10) ? SAMPLES / 4 : 0;
    localparam int KEPT         = SAMPLES - 2 * DROP;
    localparam int SUM_W        = 16 + CNT_W;
    localparam int STEP_W       = $clog2(KEPT + 25);
    localparam int ADDR_W       = 4;

    // reciprocal of KEPT, exact for every sum that fits in SUM_W bits
    localparam int RECIP_SH     = SUM_W + $clog2(KEPT);
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SH) + 64'(KEPT) - 64'd1) / 64'(KEPT);
    localparam int PROD_W       = 2 * SUM_W + 2;

    localparam logic [ADDR_W-1:0] ADDR_SCALE = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_OMIN  = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_OMAX  = 4'd8;

    typedef enum logic [3:0] {
        ST_CALIB,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SUM,
        ST_DIV,
        ST_RUN,
        ST_SQRT,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic store;      // write sample into store
        logic sort_init;  // start selection sort pass
        logic sort_rd;    // read pair for sort
        logic sort_step;  // compare/swap and advance
        logic sum_init;
        logic sum_step;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic sort_done;
        logic sum_done;
        logic div_done;
        logic sqrt_done;
    } stat_t;

endpackage

/* rtl/aoc_stream_if.sv */
// ----------------------------------------------------------------------------
// aoc_stream_if: valid/ready channel interfaces
// Input samples and output results.
// ----------------------------------------------------------------------------
interface aoc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_sample;
    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface aoc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] speed_fixed;
    logic [15:0] zero_offset;
    modport source (output valid, output speed_fixed, output zero_offset, input ready);
    modport sink   (input valid, input speed_fixed, input zero_offset, output ready);
endinterface

/* rtl/aoc_datapath.sv */
// ----------------------------------------------------------------------------
// aoc_datapath: sample store, sorter, summer, mean and square root
// One add or root bit per cycle, each compare/swap after a pair read; the mean by reciprocal multiply.
// ----------------------------------------------------------------------------
module aoc_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  aoc_pkg::cmd_t          cmd,
    output aoc_pkg::stat_t         stat,
    input  logic [15:0]            raw_sample,
    input  logic [15:0]            value_scale,
    input  logic [15:0]            offset_min,
    input  logic [15:0]            offset_max,
    output logic [15:0]            speed_fixed,
    output logic [15:0]            zero_offset
);

    logic [15:0] mem [aoc_pkg::SAMPLES];
    logic [aoc_pkg::CNT_W-1:0] count_reg;
    logic [aoc_pkg::IDX_W-1:0] i_reg, j_reg;
    logic [15:0] a_reg, b_reg;
    logic [aoc_pkg::SUM_W-1:0] sum_reg;
    logic [15:0] quo_reg;
    logic        quo_valid_reg;
    logic [aoc_pkg::STEP_W-1:0] step_reg;
    logic [15:0] offset_reg;
    logic [15:0] raw_reg;
    logic [31:0] sq_reg;
    logic [47:0] v_reg;
    logic [23:0] root_reg;
    logic [25:0] trial_rem_reg;
    logic [15:0] speed_reg;
    logic        sort_done_reg;
    logic [aoc_pkg::PROD_W-1:0] prod;
    logic [25:0] rem_try;
    logic [25:0] trial;

    localparam logic [aoc_pkg::IDX_W-1:0] LAST = aoc_pkg::IDX_W'(aoc_pkg::SAMPLES - 1);

    // sample store and sorter (selection sort over index pairs i<j)
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[count_reg[aoc_pkg::IDX_W-1:0]] <= raw_sample;
        end
        if (cmd.sort_step && b_reg < a_reg)
        begin
            mem[i_reg] <= b_reg;
            mem[j_reg] <= a_reg;
        end
        if (cmd.sort_rd)
        begin
            a_reg <= mem[i_reg];
            b_reg <= mem[j_reg];
        end
        else if (cmd.sum_step)
        begin
            a_reg <= mem[i_reg];
        end
    end

    // indexes, counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            sort_done_reg <= 1'b0;
            step_reg      <= '0;
            quo_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.store)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.sort_init)
            begin
                i_reg         <= '0;
                j_reg         <= aoc_pkg::IDX_W'(1);
                sort_done_reg <= (aoc_pkg::SAMPLES < 2);
            end
            if (cmd.sort_step)
            begin
                if (j_reg == LAST)
                begin
                    if (i_reg == LAST - aoc_pkg::IDX_W'(1))
                    begin
                        sort_done_reg <= 1'b1;
                    end
                    i_reg <= i_reg + aoc_pkg::IDX_W'(1);
                    j_reg <= i_reg + aoc_pkg::IDX_W'(2);
                end
                else
                begin
                    j_reg <= j_reg + aoc_pkg::IDX_W'(1);
                end
            end
            if (cmd.sum_init)
            begin
                i_reg    <= aoc_pkg::IDX_W'(aoc_pkg::DROP);
                step_reg <= '0;
            end
            if (cmd.sum_step)
            begin
                i_reg    <= i_reg + aoc_pkg::IDX_W'(1);
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.div_init)
            begin
                quo_valid_reg <= 1'b1;
            end
            if (cmd.div_step)
            begin
                quo_valid_reg <= 1'b0;
            end
            if (cmd.sqrt_init)
            begin
                step_reg <= '0;
            end
            if (cmd.sqrt_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // summing the kept window, a_reg holds mem[i] registered at the step before
    always_ff @(posedge clk)
    begin
        if (cmd.sum_init)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sum_step && step_reg != aoc_pkg::STEP_W'(0))
        begin
            sum_reg <= sum_reg + aoc_pkg::SUM_W'(a_reg);
        end
    end

    // mean by multiplying with the reciprocal of the kept count
    assign prod = aoc_pkg::PROD_W'(sum_reg) * aoc_pkg::PROD_W'(aoc_pkg::RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            quo_reg <= prod[aoc_pkg::RECIP_SH +: 16];
        end
    end

    // clamp the mean into offset range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (quo_valid_reg && cmd.div_step)
        begin
            if (quo_reg < offset_min)
            begin
                offset_reg <= offset_min;
            end
            else if (quo_reg > offset_max)
            begin
                offset_reg <= offset_max;
            end
            else
            begin
                offset_reg <= quo_reg;
            end
        end
    end

    // running stage: square, then bitwise root of scale^2 * diff
    assign trial   = {root_reg, 2'b01};
    assign rem_try = {trial_rem_reg[23:0], v_reg[47:46]};

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            raw_reg       <= raw_sample;
            sq_reg        <= 32'(value_scale) * 32'(value_scale);
            v_reg         <= '0;
            root_reg      <= '0;
            trial_rem_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (step_reg == aoc_pkg::STEP_W'(0))
            begin
                v_reg <= (raw_reg >= offset_reg)
                         ? 48'(sq_reg) * 48'(raw_reg - offset_reg) : 48'd0;
            end
            else
            begin
                v_reg <= {v_reg[45:0], 2'b00};
                if (rem_try >= trial)
                begin
                    trial_rem_reg <= rem_try - trial;
                    root_reg      <= {root_reg[22:0], 1'b1};
                end
                else
                begin
                    trial_rem_reg <= rem_try;
                    root_reg      <= {root_reg[22:0], 1'b0};
                end
            end
        end
        if (cmd.out_load)
        begin
            speed_reg <= (root_reg[23:16] != 8'd0) ? 16'hFFFF : root_reg[15:0];
        end
    end

    assign stat.full      = (count_reg == aoc_pkg::CNT_W'(aoc_pkg::SAMPLES));
    assign stat.sort_done = sort_done_reg;
    assign stat.sum_done  = (step_reg == aoc_pkg::STEP_W'(aoc_pkg::KEPT));
    assign stat.div_done  = quo_valid_reg;
    assign stat.sqrt_done = (step_reg == aoc_pkg::STEP_W'(24));
    assign speed_fixed    = speed_reg;
    assign zero_offset    = offset_reg;

endmodule

/* rtl/aoc_ctrl.sv */
// ----------------------------------------------------------------------------
// aoc_ctrl: sequencer for calibration and conversion
// Steps sort, sum, mean and square root, and owns the handshakes.
// ----------------------------------------------------------------------------
module aoc_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  aoc_pkg::stat_t  stat,
    output aoc_pkg::cmd_t   cmd
);

    aoc_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aoc_pkg::ST_CALIB;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            aoc_pkg::ST_CALIB:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (stat.full)
                    begin
                        cmd.sort_init = 1'b1;
                        state_next    = aoc_pkg::ST_SORT_RD;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            aoc_pkg::ST_SORT_RD:
            begin
                if (stat.sort_done)
                begin
                    cmd.sum_init = 1'b1;
                    state_next   = aoc_pkg::ST_SUM;
                end
                else
                begin
                    cmd.sort_rd = 1'b1;
                    state_next  = aoc_pkg::ST_SORT_CMP;
                end
            end
            aoc_pkg::ST_SORT_CMP:
            begin
                cmd.sort_step = 1'b1;
                state_next    = aoc_pkg::ST_SORT_RD;
            end
            aoc_pkg::ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (stat.sum_done)
                begin
                    state_next = aoc_pkg::ST_DIV;
                end
            end
            // mean on entry, clamp into the offset on the next cycle
            aoc_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_step = 1'b1;
                    state_next   = aoc_pkg::ST_RUN;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                end
            end
            aoc_pkg::ST_RUN:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = aoc_pkg::ST_SQRT;
                end
            end
            aoc_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_done)
                begin
                    state_next = aoc_pkg::ST_OUT;
                end
            end
            // wait here while the previous result is still held
            aoc_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = aoc_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = aoc_pkg::ST_CALIB;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // a result is never raised while the root is still running
    property p_out_after_sqrt;
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == aoc_pkg::ST_OUT;
    endproperty
    assert property (p_out_after_sqrt) else $error("result raised outside output step");

    property p_no_input_in_sort;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == aoc_pkg::ST_SORT_RD || state_reg == aoc_pkg::ST_SUM) |-> !in_ready;
    endproperty
    assert property (p_no_input_in_sort) else $error("input taken during calibration math");

    property p_single_pending;
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg;
    endproperty
    assert property (p_single_pending) else $error("pending result dropped");

endmodule

/* rtl/airspeed_offset_calibrate_and_convert_unit.sv */
// ----------------------------------------------------------------------------
// airspeed_offset_calibrate_and_convert_unit: trimmed-mean zero offset and
// square-root airspeed conversion
// ----------------------------------------------------------------------------
// calibrating: samples are stored as accepted; the closing sample starts a
//   sort that reads each pair before its compare/swap, then sums the kept
//   window and takes the mean and the clamp
// running: a new sample is taken only once the last result is loaded for
//   output; each result comes from a bit-serial square root (25 steps)
// reset: asynchronous, clears to calibrating with the register file at its defaults
module airspeed_offset_calibrate_and_convert_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    aoc_in_if.sink                        in_ch,
    aoc_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aoc_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [15:0] value_scale_reg, offset_min_reg, offset_max_reg;
    aoc_pkg::cmd_t  cmd;
    aoc_pkg::stat_t stat;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_scale_reg <= 16'd256;
            offset_min_reg  <= 16'd0;
            offset_max_reg  <= 16'hFFFF;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                aoc_pkg::ADDR_SCALE: value_scale_reg <= pwdata[15:0];
                aoc_pkg::ADDR_OMIN:  offset_min_reg  <= pwdata[15:0];
                aoc_pkg::ADDR_OMAX:  offset_max_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            aoc_pkg::ADDR_SCALE: prdata = {16'd0, value_scale_reg};
            aoc_pkg::ADDR_OMIN:  prdata = {16'd0, offset_min_reg};
            aoc_pkg::ADDR_OMAX:  prdata = {16'd0, offset_max_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    aoc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    aoc_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .raw_sample  (in_ch.raw_sample),
        .value_scale (value_scale_reg),
        .offset_min  (offset_min_reg),
        .offset_max  (offset_max_reg),
        .speed_fixed (out_ch.speed_fixed),
        .zero_offset (out_ch.zero_offset)
    );

endmodule

/* tb/sv/airspeed_offset_calibrate_and_convert_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// airspeed_offset_calibrate_and_convert_unit_test: self-checking bench
// Feeds a calibration set, then raw samples under several scale settings,
// with random gaps and output stalls. A scoreboard predicts the trimmed-mean
// offset and the square-root airspeed and checks every result in order.
// ----------------------------------------------------------------------------
module airspeed_offset_calibrate_and_convert_unit_test;

    localparam logic [aoc_pkg::ADDR_W-1:0] ADDR_UNUSED = 4'd12;
    localparam int SORT_WAIT = 2 * aoc_pkg::SAMPLES * aoc_pkg::SAMPLES
                               + 2 * aoc_pkg::SAMPLES + 200;
    localparam int RUN_WAIT  = 60;

    typedef struct {
        logic [15:0] speed;
        logic [15:0] offset;
    } airspeed_t;

    // predicts calibration offset and airspeed, checks results in order
    class airspeed_scoreboard;
        logic [15:0] calib_q[$];
        bit          running;
        logic [15:0] offset_value;
        logic [15:0] scale;
        logic [15:0] omin;
        logic [15:0] omax;
        airspeed_t   speed_q[$];
        int          mismatches;
        int          failures;

        function new();
            running      = 0;
            offset_value = 0;
            scale        = 256;
            omin         = 0;
            omax         = 16'hffff;
            mismatches   = 0;
            failures     = 0;
        endfunction

        function void set_reg(logic [aoc_pkg::ADDR_W-1:0] addr, logic [15:0] v);
            case (addr)
                aoc_pkg::ADDR_SCALE: scale = v;
                aoc_pkg::ADDR_OMIN:  omin  = v;
                aoc_pkg::ADDR_OMAX:  omax  = v;
                default: ;
            endcase
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] t;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return r;
        endfunction

        // sort, trim, average, clamp
        function void close_calibration();
            logic [15:0] sorted_q[$];
            logic [31:0] sum;
            logic [31:0] mean;
            sorted_q = calib_q;
            sorted_q.sort();
            sum = 0;
            for (int i = aoc_pkg::DROP; i < aoc_pkg::SAMPLES - aoc_pkg::DROP; i++)
                sum += sorted_q[i];
            mean = sum / aoc_pkg::KEPT;
            if (mean < omin)
                mean = omin;
            else if (mean > omax)
                mean = omax;
            offset_value = mean[15:0];
        endfunction

        function void note_sample(logic [15:0] raw);
            airspeed_t   r;
            logic [63:0] s;
            if (!running)
            begin
                if (calib_q.size() < aoc_pkg::SAMPLES)
                    calib_q = {calib_q, raw};
                else
                begin
                    close_calibration();
                    running = 1;
                end
                return;
            end
            s = 0;
            if (raw >= offset_value)
            begin
                s = int_sqrt(64'(scale) * 64'(scale) * 64'(raw - offset_value));
                if (s > 64'hffff)
                    s = 64'hffff;
            end
            r.speed  = s[15:0];
            r.offset = offset_value;
            speed_q = {speed_q, r};
        endfunction

        function void check_result(logic [15:0] speed, logic [15:0] offset);
            airspeed_t e;
            if (speed_q.size() == 0)
            begin
                failures++;
                $display("unexpected result speed=%0d offset=%0d", speed, offset);
                return;
            end
            e = speed_q.pop_front();
            if (speed !== e.speed || offset !== e.offset)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected speed=%0d offset=%0d, got speed=%0d offset=%0d",
                             e.speed, e.offset, speed, offset);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [aoc_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    bit   quiet;

    aoc_in_if  in_ch ();
    aoc_out_if out_ch ();

    airspeed_scoreboard sb = new();

    airspeed_offset_calibrate_and_convert_unit i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial clk = 0;
    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // run limit
    initial
    begin
        #4ms;
        $display("airspeed_offset_calibrate_and_convert_unit_test failed");
        $finish;
    end

    // result side: check, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.speed_fixed, out_ch.zero_offset);
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= 13);
    end

    // one register write, setup then access
    task write_reg(logic [aoc_pkg::ADDR_W-1:0] addr, logic [15:0] v);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= addr;
        pwdata  <= {16'($urandom_range(0, 65535)), v};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        sb.set_reg(addr, v);
    endtask

    // one request, with a random gap in front
    task send_sample(logic [15:0] raw);
        while (!quiet && $urandom_range(0, 99) < 13)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid      <= 1;
        in_ch.raw_sample <= raw;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_sample(raw);
    endtask

    // hold the sender until everything has come back
    task drain(int extra);
        in_ch.valid <= 0;
        @(posedge clk);
        while (sb.speed_q.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // samples spread around the offset, plus full-range noise
    function logic [15:0] pick_sample();
        int v;
        if ($urandom_range(0, 99) < 40)
        begin
            v = int'(sb.offset_value) + int'($urandom_range(0, 600)) - 300;
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            return v[15:0];
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        logic [15:0] base;
        logic [15:0] off;
        logic [15:0] scales[7];

        rst_n            = 0;
        psel             = 0;
        penable          = 0;
        pwrite           = 0;
        paddr            = 0;
        pwdata           = 0;
        in_ch.valid      = 0;
        in_ch.raw_sample = 0;
        out_ch.ready     = 0;
        quiet            = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // clamp window, possibly crossed
        write_reg(aoc_pkg::ADDR_OMIN, 16'($urandom_range(0, 20000)));
        write_reg(aoc_pkg::ADDR_OMAX, 16'($urandom_range(10000, 65535)));
        write_reg(ADDR_UNUSED, 16'hffff);

        // calibration set: a cluster with outliers, then the closing sample
        base = 16'($urandom_range(0, 60000));
        for (int i = 0; i < aoc_pkg::SAMPLES; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sample(16'($urandom_range(0, 65535)));
            else
                send_sample(16'(base + $urandom_range(0, 4000)));
        end
        send_sample(16'($urandom_range(0, 65535)));
        in_ch.valid <= 0;
        repeat (SORT_WAIT) @(posedge clk);

        // directed: field extremes and the offset boundary
        off = sb.offset_value;
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h5555);
        send_sample(16'haaaa);
        send_sample(off);
        send_sample(off + 16'd1);
        if (off != 0)
            send_sample(off - 16'd1);
        drain(RUN_WAIT);
        write_reg(aoc_pkg::ADDR_SCALE, 16'hffff);
        send_sample(16'hffff);
        send_sample(16'h0000);
        send_sample(off + 16'd1);
        drain(RUN_WAIT);
        write_reg(aoc_pkg::ADDR_OMIN, 16'hffff);
        write_reg(aoc_pkg::ADDR_OMAX, 16'h0000);

        // random phases across scale settings
        scales = '{16'd0, 16'hffff, 16'd1, 16'd256, 16'h0000, 16'h0000, 16'h0000};
        for (int p = 0; p < 7; p++)
        begin
            if (p >= 4)
                scales[p] = 16'($urandom_range(0, 65535));
            write_reg(aoc_pkg::ADDR_SCALE, scales[p]);
            quiet = (p == 3);
            for (int i = 0; i < 180; i++)
            begin
                send_sample(pick_sample());
                if (p == 1 && i == 90)
                    drain(0);
            end
            drain(RUN_WAIT);
        end

        if (sb.mismatches == 0 && sb.failures == 0 && sb.speed_q.size() == 0)
            $display("airspeed_offset_calibrate_and_convert_unit_test passed");
        else
            $display("airspeed_offset_calibrate_and_convert_unit_test failed");
        $finish;
    end

endmodule
